// ===== sv/cel_pkg.sv =====
// Shared types and constants for the streamed cross-entropy loss block.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package cel_pkg;

	localparam int PROB_W = 17;
	localparam int CLS_W  = 8;
	localparam int LOSS_W = 20;
	localparam int SUM_W  = 30;
	localparam int CNT_W  = 11;
	localparam int M_W    = 31;
	localparam int K_W    = 5;
	localparam int F_W    = 16;
	localparam int V_W    = 21;

	localparam logic [PROB_W-1:0] ONE_Q16      = 17'h10000;
	localparam logic [PROB_W-1:0] MIN_PROB_RST = 17'd1;
	localparam logic [31:0]       LN2_Q32      = 32'd2977044472;
	localparam logic [LOSS_W-1:0] LOSS_MAX     = 20'hFFFFF;
	localparam logic [CNT_W-1:0]  CNT_HW_MAX   = 11'd2047;

	localparam int LOG_ITERS = 16;
	localparam int DIV_STEPS = 30;

	localparam int MAX_ROWS_DEF    = 1024;
	localparam int MAX_CLASSES_DEF = 256;
	localparam int QUEUE_DEPTH     = 2;

	typedef struct packed {
		logic [PROB_W-1:0] prob;
		logic [CLS_W-1:0]  class_index;
		logic [CLS_W-1:0]  true_label;
		logic              row_end;
		logic              batch_end;
	} item_t;

	typedef struct packed {
		logic [LOSS_W-1:0] sample_loss;
		logic [LOSS_W-1:0] batch_mean;
		logic              mean_valid;
	} result_t;

	// One finished row: clamped probability and batch flag
	typedef struct packed {
		logic [PROB_W-1:0] c;
		logic              batch_end;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

// ===== sv/cel_front.sv =====
// Front end: accepts class elements, latches the true-class probability and
// pushes one clamped job per row. Depends on cel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cel_front import cel_pkg::*; #(
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire item_t             item,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PROB_W-1:0] cfg_min_prob,
	input  wire q_status_t         q_status,
	output logic                   push,
	output job_t                   job
);

	logic [PROB_W-1:0] min_prob_q;
	logic [PROB_W-1:0] picked_q;
	logic [PROB_W-1:0] prob_sat;
	logic [PROB_W-1:0] floor_p;
	logic [PROB_W-1:0] cur_pick;
	logic              match;
	logic              accept;

	assign cfg_ready  = 1'b1;
	assign item_ready = !q_status.full;
	assign accept     = item_valid && item_ready;

	// Saturate the probability and test for the true class
	always_comb begin
		prob_sat = (item.prob > ONE_Q16) ? ONE_Q16 : item.prob;
		match    = (item.class_index == item.true_label) &&
			(32'(item.class_index) < MAX_CLASSES);
		cur_pick = match ? prob_sat : picked_q;
		if (min_prob_q == '0) begin
			floor_p = PROB_W'(1);
		end else if (min_prob_q > ONE_Q16) begin
			floor_p = ONE_Q16;
		end else begin
			floor_p = min_prob_q;
		end
		job.c         = (cur_pick > floor_p) ? cur_pick : floor_p;
		job.batch_end = item.batch_end;
	end

	assign push = accept && item.row_end;

	// Hold the clamp register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_prob_q <= MIN_PROB_RST;
		end else if (cfg_valid && cfg_ready) begin
			min_prob_q <= cfg_min_prob;
		end
	end

	// Latch the picked probability, drop it at row end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			picked_q <= '0;
		end else if (accept) begin
			if (item.row_end) begin
				picked_q <= '0;
			end else if (match) begin
				picked_q <= prob_sat;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/cel_fifo.sv =====
// Short job queue between front and back ends.
// Depends on cel_pkg for the job and status types.
`timescale 1ns / 1ps
`default_nettype none

module cel_fifo import cel_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire job_t  push_job,
	input  wire logic  pop,
	output job_t       head,
	output q_status_t  status
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	job_t          mem [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign head         = mem[rd_ptr_q];

	// Store pushed jobs
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_job;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/cel_back.sv =====
// Back end: per-row -ln by repeated squaring, loss accumulation and the
// batch-end mean by restoring division. Depends on cel_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cel_back import cel_pkg::*; #(
	parameter int MAX_ROWS = MAX_ROWS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire job_t      head,
	input  wire q_status_t q_status,
	output logic           pop,
	output logic           result_valid,
	input  wire logic      result_ready,
	output result_t        result
);

	localparam logic [CNT_W-1:0] CAP =
		(MAX_ROWS < 2047) ? CNT_W'(MAX_ROWS) : CNT_HW_MAX;

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_SQR  = 6'b000010,
		ST_MUL  = 6'b000100,
		ST_ACC  = 6'b001000,
		ST_DIV  = 6'b010000,
		ST_OUT  = 6'b100000
	} state_t;

	state_t            state_q;
	logic [M_W-1:0]    m_q;
	logic [K_W-1:0]    k_q;
	logic [F_W-1:0]    f_q;
	logic [3:0]        iter_q;
	logic              batch_q;
	logic [LOSS_W-1:0] loss_q;
	logic [SUM_W-1:0]  sum_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [SUM_W-1:0]  quo_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  divisor_q;
	logic [4:0]        step_q;
	logic              res_valid_q;
	result_t           res_q;

	logic [K_W-1:0]    k_d;
	logic [M_W-1:0]    m_norm;
	logic [61:0]       sq;
	logic [31:0]       sq_top;
	logic [V_W-1:0]    v;
	logic [52:0]       lprod;
	logic [SUM_W:0]    sum_ext;
	logic [SUM_W-1:0]  sum_new;
	logic [CNT_W-1:0]  cnt_new;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    trial_sub;
	logic              out_free;

	assign pop          = (state_q == ST_IDLE) && !q_status.empty;
	assign out_free     = !res_valid_q || result_ready;
	assign result_valid = res_valid_q;
	assign result       = res_q;

	// Find the leading one and normalise to Q1.30
	always_comb begin
		k_d = '0;
		for (int i = 1; i < PROB_W; i++) begin
			if (head.c[i]) begin
				k_d = K_W'(i);
			end
		end
		m_norm = M_W'(head.c) << (K_W'(30) - k_d);
	end

	// Square the mantissa and take the next log2 fraction bit
	assign sq     = m_q * m_q;
	assign sq_top = sq[61:30];

	// Scale log2 by ln 2 with rounding
	assign v     = V_W'(21'd1 << 20) - {k_q, f_q};
	assign lprod = 53'(v) * 53'(LN2_Q32) + 53'(64'd1 << 31);

	// Saturating accumulate and row count
	always_comb begin
		sum_ext = {1'b0, sum_q} + (SUM_W + 1)'(loss_q);
		sum_new = sum_ext[SUM_W] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
		cnt_new = (cnt_q < CAP) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	// One restoring division step
	assign trial     = {rem_q, quo_q[SUM_W-1]};
	assign trial_sub = trial - {1'b0, divisor_q};

	// Sequence one job through log, accumulate and, at batch end, divide
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			iter_q      <= '0;
			step_q      <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// Raise the result when it is loaded, drop it once taken
			if (state_q == ST_OUT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (result_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						state_q <= ST_SQR;
						iter_q  <= '0;
					end
				end
				ST_SQR: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'(LOG_ITERS - 1)) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (batch_q) begin
						sum_q   <= '0;
						cnt_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end else begin
						sum_q   <= sum_new;
						cnt_q   <= cnt_new;
						state_q <= ST_OUT;
					end
				end
				ST_DIV: begin
					step_q <= step_q + 5'd1;
					if (step_q == 5'(DIV_STEPS - 1)) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (pop) begin
					m_q     <= m_norm;
					k_q     <= k_d;
					f_q     <= '0;
					batch_q <= head.batch_end;
				end
			end
			ST_SQR: begin
				if (sq_top[31]) begin
					m_q <= sq_top[31:1];
					f_q <= {f_q[F_W-2:0], 1'b1};
				end else begin
					m_q <= sq_top[30:0];
					f_q <= {f_q[F_W-2:0], 1'b0};
				end
			end
			ST_MUL: begin
				loss_q <= lprod[51:32];
			end
			ST_ACC: begin
				quo_q     <= sum_new;
				divisor_q <= cnt_new;
				rem_q     <= '0;
			end
			ST_DIV: begin
				if (!trial_sub[CNT_W]) begin
					rem_q <= trial_sub[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial[CNT_W-1:0];
					quo_q <= {quo_q[SUM_W-2:0], 1'b0};
				end
			end
			ST_OUT: begin
				if (out_free) begin
					res_q.sample_loss <= loss_q;
					res_q.mean_valid  <= batch_q;
					if (!batch_q) begin
						res_q.batch_mean <= '0;
					end else if (quo_q > SUM_W'(LOSS_MAX)) begin
						res_q.batch_mean <= LOSS_MAX;
					end else begin
						res_q.batch_mean <= quo_q[LOSS_W-1:0];
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Row count never passes its cap
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP)
		else $error("row count above cap");

	// Division never runs with a zero divisor
	a_div_nz: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (divisor_q != '0))
		else $error("zero divisor");

	// Partial remainder stays below the divisor
	a_rem_lt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < divisor_q))
		else $error("remainder not reduced");

	// Batch end leaves the accumulator cleared
	a_batch_clr: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ACC && batch_q) |=> (sum_q == '0 && cnt_q == '0))
		else $error("accumulator not cleared at batch end");

	// A result without the mean flag carries a zero mean
	a_mean_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && !res_q.mean_valid) |-> (res_q.batch_mean == '0))
		else $error("stray batch mean");

endmodule

`default_nettype wire

// ===== sv/cross_entropy_loss_mean_top.sv =====
// Top level of the streamed cross-entropy loss block: front end, job queue
// and back end. Depends on cel_pkg, cel_front, cel_fifo and cel_back.
//
//   port group   | handshake                 | payload
//   -------------+---------------------------+------------------------------
//   item         | item_valid / item_ready   | item_t: prob, class, label, ends
//   result       | result_valid/result_ready | result_t: loss, mean, mean flag
//   cfg          | cfg_valid / cfg_ready     | cfg_min_prob (17 bits, Q1.16)
//
// The front end takes one element per cycle while the job queue has room.
// Each row passes the back end in order: one normalise, 16 squaring steps
// on the 31x31 squaring multiplier, one ln 2 scale, one accumulate, one output.
// A batch-end row adds 30 steps of one-bit-per-cycle division for the mean.
// A full queue stalls the item side; a stalled result stalls the back end and, once the queue fills, the item side.
// Reset (arst_n low) clears sum, count, picked probability and sets min_prob 1.
`timescale 1ns / 1ps
`default_nettype none

module cross_entropy_loss_mean_top import cel_pkg::*; #(
	parameter int MAX_ROWS    = MAX_ROWS_DEF,
	parameter int MAX_CLASSES = MAX_CLASSES_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire item_t             item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output result_t                result,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [PROB_W-1:0] cfg_min_prob
);

	q_status_t q_status;
	logic      push;
	logic      pop;
	job_t      push_job;
	job_t      head;

	cel_front #(
		.MAX_CLASSES(MAX_CLASSES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_min_prob(cfg_min_prob),
		.q_status    (q_status),
		.push        (push),
		.job         (push_job)
	);

	cel_fifo #(
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_job(push_job),
		.pop     (pop),
		.head    (head),
		.status  (q_status)
	);

	cel_back #(
		.MAX_ROWS(MAX_ROWS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.q_status    (q_status),
		.pop         (pop),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

endmodule

`default_nettype wire
